FILE: hdl/hbse_pkg.sv
`timescale 1ns / 1ps

package hbse_pkg;

   localparam int KEY_W  = 64;
   localparam int OCC_W  = 14;
   localparam int CMD_W  = 2;
   localparam int STAT_W = 2;
   localparam int LOG2_W = 4;

   localparam int DEF_NUM_BINS        = 1024;
   localparam int DEF_WAYS_PER_BUCKET = 4;
   localparam int DEF_BUCKETS_PER_BIN = 2;

   localparam int LOG2_RESET = 10;

   localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PUT    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
   localparam logic [STAT_W-1:0] ST_ZERO = 2'd3;

   typedef struct packed {
      logic              wr_en;
      logic              inc;
      logic              dec;
      logic [STAT_W-1:0] status;
   } row_result_type;

endpackage

FILE: hdl/bucketed_hash_set_engine_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Beat
// req_     in         req_cmd, req_lookup_key
// rsp_     out        rsp_status, rsp_occupancy
// csr_     in         csr_bins_in_use_log2
//
// Each request takes two steps: the bin row read from the RAM, and then the compare of all
// slots and the write back of the row.
// After reset the RAM is swept clear, one row per cycle, over all NUM_BINS rows; no
// request is accepted during the sweep, while register writes are always taken.
// A new request is accepted while the previous response still waits; the row update
// holds until the response register is free.

module bucketed_hash_set_engine_core
   import hbse_pkg::*;
#(
   parameter int NUM_BINS        = DEF_NUM_BINS,
   parameter int WAYS_PER_BUCKET = DEF_WAYS_PER_BUCKET,
   parameter int BUCKETS_PER_BIN = DEF_BUCKETS_PER_BIN
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [KEY_W-1:0]  req_lookup_key,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [OCC_W-1:0]  rsp_occupancy,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [LOG2_W-1:0] csr_bins_in_use_log2
);

   localparam int SLOTS     = WAYS_PER_BUCKET * BUCKETS_PER_BIN;
   localparam int ROW_W     = SLOTS * KEY_W;
   localparam int BIN_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int MAX_LOG2  = $clog2(NUM_BINS + 1) - 1;
   localparam int LOG2_INIT = (LOG2_RESET > MAX_LOG2) ? MAX_LOG2 : LOG2_RESET;

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_LOOKUP = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [BIN_W-1:0]  clr_ptr_ff, clr_ptr_in;
   logic [LOG2_W-1:0] log2_ff, log2_in;
   logic [CMD_W-1:0]  cmd_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [BIN_W-1:0]  bin_ff;
   logic [OCC_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [OCC_W-1:0]  rsp_occupancy_ff;

   logic              req_fire;
   logic              finish;
   logic [BIN_W-1:0]  bin_mask;
   logic [BIN_W-1:0]  req_bin;
   logic              mem_wr_en;
   logic [BIN_W-1:0]  mem_wr_addr;
   logic [ROW_W-1:0]  mem_wr_data;
   logic [ROW_W-1:0]  row_rd;
   logic [ROW_W-1:0]  row_new;
   row_result_type    res;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign finish    = (state_ff == S_LOOKUP) && (!rsp_valid_ff || rsp_ready);

   assign bin_mask = ~({BIN_W{1'b1}} << log2_ff);
   assign req_bin  = req_lookup_key[BIN_W-1:0] & bin_mask;

   always_comb begin
      log2_in = log2_ff;
      if (csr_valid && csr_ready) begin
         if (int'(csr_bins_in_use_log2) > MAX_LOG2) begin
            log2_in = LOG2_W'(MAX_LOG2);
         end else begin
            log2_in = csr_bins_in_use_log2;
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_ptr_in = clr_ptr_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_ptr_in = clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == BIN_W'(NUM_BINS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (finish && res.inc) begin
         count_in = count_ff + 1'b1;
      end else if (finish && res.dec) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ptr_ff   <= '0;
         log2_ff      <= LOG2_W'(LOG2_INIT);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         log2_ff      <= log2_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff <= req_cmd;
         key_ff <= req_lookup_key;
         bin_ff <= req_bin;
      end
      if (finish) begin
         rsp_status_ff    <= res.status;
         rsp_occupancy_ff <= count_in;
      end
   end

   assign mem_wr_en   = (state_ff == S_CLEAR) || (finish && res.wr_en);
   assign mem_wr_addr = (state_ff == S_CLEAR) ? clr_ptr_ff : bin_ff;
   assign mem_wr_data = (state_ff == S_CLEAR) ? '0 : row_new;

   hbse_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_BINS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_bin),
      .rd_data (row_rd)
   );

   hbse_row_update #(
      .SLOTS (SLOTS)
   ) u_update (
      .cmd     (cmd_ff),
      .key     (key_ff),
      .row_in  (row_rd),
      .row_out (row_new),
      .res     (res)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

   a_fire_to_lookup: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_LOOKUP)
      else $error("accepted request did not move to lookup");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !mem_wr_en)
      else $error("row write while idle");

   a_rsp_after_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_LOOKUP)
      else $error("response raised without a lookup");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == $past(count_ff)
         || count_ff == OCC_W'($past(count_ff) + 1'b1)
         || count_ff == OCC_W'($past(count_ff) - 1'b1))
      else $error("occupancy changed by more than one");

   a_zero_key_no_write: assert property (@(posedge clock) disable iff (reset)
      finish && key_ff == '0 |-> !mem_wr_en && res.status == ST_ZERO)
      else $error("zero key changed the store");

endmodule

FILE: hdl/hbse_ram.sv
`timescale 1ns / 1ps

module hbse_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/hbse_row_update.sv
`timescale 1ns / 1ps

module hbse_row_update
   import hbse_pkg::*;
#(
   parameter int SLOTS = 8,
   localparam int ROW_W  = SLOTS * KEY_W,
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic [CMD_W-1:0]  cmd,
   input  logic [KEY_W-1:0]  key,
   input  logic [ROW_W-1:0]  row_in,
   output logic [ROW_W-1:0]  row_out,
   output row_result_type    res
);

   logic              hit_found;
   logic              empty_found;
   logic [SLOT_W-1:0] hit_idx;
   logic [SLOT_W-1:0] empty_idx;
   logic              do_insert;
   logic              do_clear;

   always_comb begin
      hit_found   = 1'b0;
      empty_found = 1'b0;
      hit_idx     = '0;
      empty_idx   = '0;
      for (int s = 0; s < SLOTS; s++) begin
         if (!hit_found && row_in[s*KEY_W +: KEY_W] == key) begin
            hit_found = 1'b1;
            hit_idx   = SLOT_W'(s);
         end
         if (!empty_found && row_in[s*KEY_W +: KEY_W] == '0) begin
            empty_found = 1'b1;
            empty_idx   = SLOT_W'(s);
         end
      end
   end

   always_comb begin
      res       = '0;
      do_insert = 1'b0;
      do_clear  = 1'b0;
      if (key == '0) begin
         res.status = ST_ZERO;
      end else begin
         unique case (cmd)
            CMD_PUT: begin
               if (hit_found) begin
                  res.status = ST_MISS;
               end else if (empty_found) begin
                  res.status = ST_OK;
                  res.wr_en  = 1'b1;
                  res.inc    = 1'b1;
                  do_insert  = 1'b1;
               end else begin
                  res.status = ST_FULL;
               end
            end
            CMD_REMOVE: begin
               if (hit_found) begin
                  res.status = ST_OK;
                  res.wr_en  = 1'b1;
                  res.dec    = 1'b1;
                  do_clear   = 1'b1;
               end else begin
                  res.status = ST_MISS;
               end
            end
            default: begin
               res.status = hit_found ? ST_OK : ST_MISS;
            end
         endcase
      end
   end

   always_comb begin
      row_out = row_in;
      for (int s = 0; s < SLOTS; s++) begin
         if (do_insert && empty_idx == SLOT_W'(s)) begin
            row_out[s*KEY_W +: KEY_W] = key;
         end
         if (do_clear && hit_idx == SLOT_W'(s)) begin
            row_out[s*KEY_W +: KEY_W] = '0;
         end
      end
   end

endmodule
